@@ src/lrc_pkg.sv @@
// Shared types and constants of the clipped line rasterizer.
package lrc_pkg;

  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned COLOUR_BITS = 8;
  localparam int unsigned CFG_INDEX_BITS = 2;

  localparam int CLIP_X_LOW_RESET = 180;
  localparam int CLIP_X_HIGH_RESET = 979;
  localparam int CLIP_Y_LOW_RESET = 50;
  localparam int CLIP_Y_HIGH_RESET = 649;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_STEP = 1'b1
  } kind_e;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_CLIP_X_LOW = 2'd0,
    REG_CLIP_X_HIGH = 2'd1,
    REG_CLIP_Y_LOW = 2'd2,
    REG_CLIP_Y_HIGH = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [COLOUR_BITS-1:0] red;
    logic [COLOUR_BITS-1:0] green;
    logic [COLOUR_BITS-1:0] blue;
  } colour_t;

endpackage

@@ src/lrc_if.sv @@
// Request and pixel channel interfaces of the clipped line rasterizer.
interface lrc_in_if import lrc_pkg::*; #(
  parameter int unsigned CoordBits = COORD_BITS
) ();
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic signed [CoordBits-1:0]  start_x;
  logic signed [CoordBits-1:0]  start_y;
  logic signed [CoordBits-1:0]  finish_x;
  logic signed [CoordBits-1:0]  finish_y;
  logic [COLOUR_BITS-1:0]       red_in;
  logic [COLOUR_BITS-1:0]       green_in;
  logic [COLOUR_BITS-1:0]       blue_in;

  modport source (
    output valid, kind, start_x, start_y, finish_x, finish_y, red_in, green_in, blue_in,
    input  ready
  );
  modport sink (
    input  valid, kind, start_x, start_y, finish_x, finish_y, red_in, green_in, blue_in,
    output ready
  );
endinterface

interface lrc_out_if import lrc_pkg::*; #(
  parameter int unsigned CoordBits = COORD_BITS
) ();
  logic                         valid;
  logic                         ready;
  logic signed [CoordBits-1:0]  pixel_x;
  logic signed [CoordBits-1:0]  pixel_y;
  logic [COLOUR_BITS-1:0]       pixel_red;
  logic [COLOUR_BITS-1:0]       pixel_green;
  logic [COLOUR_BITS-1:0]       pixel_blue;
  logic                         inside_clip;
  logic                         final_pixel;

  modport source (
    output valid, pixel_x, pixel_y, pixel_red, pixel_green, pixel_blue, inside_clip,
           final_pixel,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_red, pixel_green, pixel_blue, inside_clip,
           final_pixel,
    output ready
  );
endinterface

@@ src/lrc_clip.sv @@
// Clip window registers and the inclusive window test on a pixel coordinate.
module lrc_clip import lrc_pkg::*; #(
  parameter int unsigned CoordBits = COORD_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CFG_INDEX_BITS-1:0]   cfg_index_i,
  input  logic [CoordBits-1:0]        cfg_data_i,
  input  logic signed [CoordBits-1:0] x_i,
  input  logic signed [CoordBits-1:0] y_i,
  output logic                        inside_o
);

  logic signed [CoordBits-1:0] x_low_q, x_high_q, y_low_q, y_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_low_q  <= CoordBits'(CLIP_X_LOW_RESET);
      x_high_q <= CoordBits'(CLIP_X_HIGH_RESET);
      y_low_q  <= CoordBits'(CLIP_Y_LOW_RESET);
      y_high_q <= CoordBits'(CLIP_Y_HIGH_RESET);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_CLIP_X_LOW:  x_low_q  <= cfg_data_i;
        REG_CLIP_X_HIGH: x_high_q <= cfg_data_i;
        REG_CLIP_Y_LOW:  y_low_q  <= cfg_data_i;
        REG_CLIP_Y_HIGH: y_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign inside_o = (x_i >= x_low_q) && (x_i <= x_high_q) &&
                    (y_i >= y_low_q) && (y_i <= y_high_q);

endmodule

@@ src/lrc_step.sv @@
// Line state and the Bresenham load and step update.
module lrc_step import lrc_pkg::*; #(
  parameter int unsigned CoordBits = COORD_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        take_i,
  input  logic                        kind_i,
  input  logic signed [CoordBits-1:0] start_x_i,
  input  logic signed [CoordBits-1:0] start_y_i,
  input  logic signed [CoordBits-1:0] finish_x_i,
  input  logic signed [CoordBits-1:0] finish_y_i,
  input  colour_t                     colour_i,
  output logic                        emit_o,
  output logic signed [CoordBits-1:0] cursor_x_o,
  output logic signed [CoordBits-1:0] cursor_y_o,
  output colour_t                     colour_o,
  output logic                        final_o
);

  localparam int unsigned SpanBits = CoordBits + 1;
  localparam int unsigned ErrBits  = CoordBits + 2;
  localparam int unsigned WideBits = CoordBits + 3;

  logic signed [CoordBits-1:0] cursor_x_q, cursor_x_d, cursor_y_q, cursor_y_d;
  logic signed [CoordBits-1:0] goal_x_q, goal_x_d, goal_y_q, goal_y_d;
  logic                        neg_x_q, neg_x_d, neg_y_q, neg_y_d;
  logic [CoordBits-1:0]        span_x_q, span_x_d;
  logic signed [SpanBits-1:0]  span_y_neg_q, span_y_neg_d;
  logic signed [ErrBits-1:0]   err_q, err_d;
  logic                        running_q, running_d;
  colour_t                     colour_q, colour_d;

  logic signed [SpanBits-1:0]  dx, dy;
  logic [CoordBits-1:0]        load_span_x;
  logic signed [SpanBits-1:0]  load_span_y_neg;
  logic signed [WideBits-1:0]  e2, sx_wide, syn_wide, err_sum;
  logic                        move_x, move_y, last;

  always_comb begin
    dx = SpanBits'(finish_x_i) - SpanBits'(start_x_i);
    dy = SpanBits'(finish_y_i) - SpanBits'(start_y_i);
    load_span_x = dx[SpanBits-1] ? CoordBits'(-dx) : CoordBits'(dx);
    load_span_y_neg = dy[SpanBits-1] ? dy : -dy;

    last = (cursor_x_q == goal_x_q) && (cursor_y_q == goal_y_q);
    e2 = WideBits'({err_q, 1'b0});
    sx_wide = WideBits'(signed'({1'b0, span_x_q}));
    syn_wide = WideBits'(span_y_neg_q);
    move_x = e2 >= syn_wide;
    move_y = e2 <= sx_wide;
    err_sum = WideBits'(err_q) + (move_x ? syn_wide : '0) + (move_y ? sx_wide : '0);

    cursor_x_d   = cursor_x_q;
    cursor_y_d   = cursor_y_q;
    goal_x_d     = goal_x_q;
    goal_y_d     = goal_y_q;
    neg_x_d      = neg_x_q;
    neg_y_d      = neg_y_q;
    span_x_d     = span_x_q;
    span_y_neg_d = span_y_neg_q;
    err_d        = err_q;
    running_d    = running_q;
    colour_d     = colour_q;
    emit_o       = 1'b0;

    if (take_i) begin
      if (kind_e'(kind_i) == KIND_LOAD) begin
        cursor_x_d   = start_x_i;
        cursor_y_d   = start_y_i;
        goal_x_d     = finish_x_i;
        goal_y_d     = finish_y_i;
        neg_x_d      = !(start_x_i < finish_x_i);
        neg_y_d      = !(start_y_i < finish_y_i);
        span_x_d     = load_span_x;
        span_y_neg_d = load_span_y_neg;
        err_d        = ErrBits'(signed'({1'b0, load_span_x})) + ErrBits'(load_span_y_neg);
        colour_d     = colour_i;
        running_d    = 1'b1;
      end else if (running_q) begin
        emit_o = 1'b1;
        if (last) begin
          running_d = 1'b0;
        end else begin
          err_d = err_sum[ErrBits-1:0];
          if (move_x) begin
            cursor_x_d = neg_x_q ? cursor_x_q - 1'b1 : cursor_x_q + 1'b1;
          end
          if (move_y) begin
            cursor_y_d = neg_y_q ? cursor_y_q - 1'b1 : cursor_y_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q   <= '0;
      cursor_y_q   <= '0;
      goal_x_q     <= '0;
      goal_y_q     <= '0;
      neg_x_q      <= 1'b0;
      neg_y_q      <= 1'b0;
      span_x_q     <= '0;
      span_y_neg_q <= '0;
      err_q        <= '0;
      running_q    <= 1'b0;
      colour_q     <= '0;
    end else begin
      cursor_x_q   <= cursor_x_d;
      cursor_y_q   <= cursor_y_d;
      goal_x_q     <= goal_x_d;
      goal_y_q     <= goal_y_d;
      neg_x_q      <= neg_x_d;
      neg_y_q      <= neg_y_d;
      span_x_q     <= span_x_d;
      span_y_neg_q <= span_y_neg_d;
      err_q        <= err_d;
      running_q    <= running_d;
      colour_q     <= colour_d;
    end
  end

  assign cursor_x_o = cursor_x_q;
  assign cursor_y_o = cursor_y_q;
  assign colour_o   = colour_q;
  assign final_o    = last;

endmodule

@@ src/line_rasterizer_clipped_top.sv @@
// Top level of the clipped Bresenham line rasterizer.
// A load request latches two endpoints and a colour and gives no pixel; each step request
// then gives one pixel of the line, flagged against the inclusive clip window, with the
// second endpoint marked final, and step requests after that give nothing. The line state
// updates in the cycle a request is accepted and the pixel appears on the output register in
// the next cycle, so one pixel per cycle is sustained while the pixel sink keeps ready high.
// The clip registers are written through the plain write port.
module line_rasterizer_clipped_top import lrc_pkg::*; #(
  parameter int unsigned CoordBits = COORD_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [CoordBits-1:0]      cfg_data_i,
  lrc_in_if.sink                    req_i,
  lrc_out_if.source                 pix_o
);

  logic                        take, emit, in_window, last;
  logic signed [CoordBits-1:0] cursor_x, cursor_y;
  colour_t                     colour_in, colour;

  logic                        out_valid_q, out_valid_d;
  logic signed [CoordBits-1:0] pix_x_q, pix_y_q;
  colour_t                     pix_colour_q;
  logic                        inside_q, final_q;

  assign req_i.ready = !out_valid_q || pix_o.ready;
  assign take = req_i.valid && req_i.ready;
  assign colour_in = '{red: req_i.red_in, green: req_i.green_in, blue: req_i.blue_in};

  lrc_step #(.CoordBits(CoordBits)) u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .kind_i     (req_i.kind),
    .start_x_i  (req_i.start_x),
    .start_y_i  (req_i.start_y),
    .finish_x_i (req_i.finish_x),
    .finish_y_i (req_i.finish_y),
    .colour_i   (colour_in),
    .emit_o     (emit),
    .cursor_x_o (cursor_x),
    .cursor_y_o (cursor_y),
    .colour_o   (colour),
    .final_o    (last)
  );

  lrc_clip #(.CoordBits(CoordBits)) u_clip (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .x_i         (cursor_x),
    .y_i         (cursor_y),
    .inside_o    (in_window)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (pix_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      pix_x_q      <= cursor_x;
      pix_y_q      <= cursor_y;
      pix_colour_q <= colour;
      inside_q     <= in_window;
      final_q      <= last;
    end
  end

  assign pix_o.valid       = out_valid_q;
  assign pix_o.pixel_x     = pix_x_q;
  assign pix_o.pixel_y     = pix_y_q;
  assign pix_o.pixel_red   = pix_colour_q.red;
  assign pix_o.pixel_green = pix_colour_q.green;
  assign pix_o.pixel_blue  = pix_colour_q.blue;
  assign pix_o.inside_clip = inside_q;
  assign pix_o.final_pixel = final_q;

endmodule
